### hw/rtl/mec_pkg.sv
// shared types and constants of the mouse event classifier
package mec_pkg;

	// width of the millisecond timestamp; differences wrap at this width
	localparam int unsigned TIME_W = 32;

	// buttons that take part in the left/right swap
	localparam logic [2:0] LR_BITS = 3'b011;

	// tick count used when a delay register holds zero
	localparam logic [7:0] DEFAULT_TICKS = 8'd8;

	// event kinds
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_PRESS   = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_MOVE    = 3'd3;
	localparam logic [2:0] EV_REPEAT  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_DOUBLE_DELAY = 3'd0;
	localparam logic [2:0] REG_REPEAT_DELAY = 3'd1;
	localparam logic [2:0] REG_SWAP         = 3'd2;
	localparam logic [2:0] REG_PIXEL_MODE   = 3'd3;
	localparam logic [2:0] REG_PRESENT      = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		logic [2:0]        buttons;
		logic [7:0]        cell_x;
		logic [7:0]        cell_y;
		logic [11:0]       pixel_x;
		logic [11:0]       pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  out_buttons;
		logic        double_click;
		logic [7:0]  where_x;
		logic [7:0]  where_y;
		logic [11:0] where_px;
		logic [11:0] where_py;
		logic [7:0]  from_x;
		logic [7:0]  from_y;
	} out_item_t;

	typedef struct packed {
		logic [7:0] double_delay_ticks;
		logic [7:0] repeat_delay_ticks;
		logic       swap_buttons;
		logic       pixel_mode;
		logic       mouse_present;
	} cfg_t;

endpackage

### hw/rtl/mouse_event_classifier.sv
// top level of the mouse event classifier: handshake, registers and result stage
// Each accepted pointer sample yields exactly one result transaction, in order:
// nothing, press, release, move or auto-repeat, with the effective buttons,
// the double-click flag and positions (all fields zero for nothing). An accepted
// sample is held in the input register, which feeds the decision logic, and its
// result is caught in the result register when the sample moves on. The tracking
// state is updated in the same cycle the result is registered, so a new sample
// can be accepted every cycle and the throughput is one per cycle; it drops
// only while the result register is full and out_ready is low.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata and should
// only change while no sample is in flight. TICK_MS sets the tick length of
// the double-click and auto-repeat delays and the auto-repeat period.
module mouse_event_classifier #(
	parameter int unsigned TICK_MS = 55
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample channel
	input  logic               in_valid,
	output logic               in_ready,
	input  mec_pkg::in_item_t  in_data,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output mec_pkg::out_item_t out_data,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_addr,
	input  logic [7:0]         cfg_wdata
);

	mec_pkg::cfg_t      cfg_q;
	mec_pkg::in_item_t  item_s1;
	logic               valid_s1;
	mec_pkg::out_item_t result;
	mec_pkg::out_item_t out_data_s2;
	logic               out_valid_s2;
	logic               advance;

	// configuration registers, reset to their documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_delay_ticks <= 8'd8;
			cfg_q.repeat_delay_ticks <= 8'd8;
			cfg_q.swap_buttons       <= 1'b0;
			cfg_q.pixel_mode         <= 1'b0;
			cfg_q.mouse_present      <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				mec_pkg::REG_DOUBLE_DELAY: cfg_q.double_delay_ticks <= cfg_wdata;
				mec_pkg::REG_REPEAT_DELAY: cfg_q.repeat_delay_ticks <= cfg_wdata;
				mec_pkg::REG_SWAP:         cfg_q.swap_buttons       <= cfg_wdata[0];
				mec_pkg::REG_PIXEL_MODE:   cfg_q.pixel_mode         <= cfg_wdata[0];
				mec_pkg::REG_PRESENT:      cfg_q.mouse_present      <= cfg_wdata[0];
				default: ; // unused indexes are ignored
			endcase
		end
	end

	// the sample in stage 1 moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	mec_core #(
		.TICK_MS (TICK_MS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.commit (advance),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

### hw/rtl/mec_core.sv
// event decision logic and the tracking state it reads and updates
module mec_core #(
	parameter int unsigned TICK_MS = 55
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mec_pkg::cfg_t     cfg,
	input  mec_pkg::in_item_t item,
	input  logic              commit,
	output mec_pkg::out_item_t result
);

	localparam int unsigned WAIT_W = $clog2(255 * TICK_MS + 1);
	localparam int unsigned TW     = mec_pkg::TIME_W;

	// tracking state
	logic [2:0]    prev_buttons_q;
	logic          prev_double_q;
	logic [7:0]    prev_cell_x_q;
	logic [7:0]    prev_cell_y_q;
	logic [11:0]   prev_pixel_x_q;
	logic [11:0]   prev_pixel_y_q;
	logic [2:0]    press_buttons_q;
	logic [7:0]    press_cell_x_q;
	logic [7:0]    press_cell_y_q;
	logic [TW-1:0] press_time_q;
	logic [TW-1:0] repeat_base_q;
	logic [WAIT_W-1:0] repeat_wait_q;

	logic [7:0]        dbl_ticks;
	logic [7:0]        rep_ticks;
	logic [WAIT_W-1:0] dbl_delay;
	logic [WAIT_W-1:0] rep_delay;
	logic [2:0]        lr;
	logic [2:0]        btn_sw;
	logic [2:0]        btn_eff;
	logic [TW-1:0]     dt_press;
	logic [TW-1:0]     dt_repeat;
	logic              moved;
	logic              dbl;
	logic [2:0]        kind;

	// zero ticks selects the default window
	assign dbl_ticks = (cfg.double_delay_ticks != 8'd0) ? cfg.double_delay_ticks
		: mec_pkg::DEFAULT_TICKS;
	assign rep_ticks = (cfg.repeat_delay_ticks != 8'd0) ? cfg.repeat_delay_ticks
		: mec_pkg::DEFAULT_TICKS;
	assign dbl_delay = WAIT_W'(dbl_ticks * TICK_MS);
	assign rep_delay = WAIT_W'(rep_ticks * TICK_MS);

	assign lr        = item.buttons & mec_pkg::LR_BITS;
	assign btn_sw    = (cfg.swap_buttons && lr != 3'd0 && lr != mec_pkg::LR_BITS)
		? (item.buttons ^ mec_pkg::LR_BITS) : item.buttons;
	assign dt_press  = item.time_ms - press_time_q;
	assign dt_repeat = item.time_ms - repeat_base_q;
	assign moved     = cfg.pixel_mode
		? (item.pixel_x != prev_pixel_x_q || item.pixel_y != prev_pixel_y_q)
		: (item.cell_x != prev_cell_x_q || item.cell_y != prev_cell_y_q);

	always_comb begin
		kind    = mec_pkg::EV_NONE;
		dbl     = prev_double_q;
		btn_eff = btn_sw;
		if (prev_buttons_q != btn_sw) begin
			if (prev_buttons_q == 3'd0) begin
				kind = mec_pkg::EV_PRESS;
				dbl  = (btn_sw == press_buttons_q) && (item.cell_x == press_cell_x_q)
					&& (item.cell_y == press_cell_y_q)
					&& (dt_press < TW'(dbl_delay));
			end else if (btn_sw == 3'd0) begin
				kind = mec_pkg::EV_RELEASE;
			end else begin
				// second button change while held: keep the held set
				btn_eff = prev_buttons_q;
			end
		end
		if (kind == mec_pkg::EV_NONE && btn_eff != 3'd0) begin
			if (moved) begin
				kind = mec_pkg::EV_MOVE;
			end else if (dt_repeat >= TW'(repeat_wait_q)) begin
				kind = mec_pkg::EV_REPEAT;
			end
		end
		if (!cfg.mouse_present) begin
			kind = mec_pkg::EV_NONE;
		end
	end

	always_comb begin
		result = '0;
		if (kind != mec_pkg::EV_NONE) begin
			result.event_kind   = kind;
			result.out_buttons  = btn_eff;
			result.double_click = dbl;
			result.where_x      = item.cell_x;
			result.where_y      = item.cell_y;
			result.where_px     = item.pixel_x;
			result.where_py     = item.pixel_y;
			if (kind == mec_pkg::EV_MOVE) begin
				result.from_x = prev_cell_x_q;
				result.from_y = prev_cell_y_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q  <= '0;
			prev_double_q   <= 1'b0;
			prev_cell_x_q   <= '0;
			prev_cell_y_q   <= '0;
			prev_pixel_x_q  <= '0;
			prev_pixel_y_q  <= '0;
			press_buttons_q <= '0;
			press_cell_x_q  <= '0;
			press_cell_y_q  <= '0;
			press_time_q    <= '0;
			repeat_base_q   <= '0;
			repeat_wait_q   <= '0;
		end else if (commit && kind != mec_pkg::EV_NONE) begin
			prev_buttons_q <= btn_eff;
			prev_double_q  <= dbl;
			prev_cell_x_q  <= item.cell_x;
			prev_cell_y_q  <= item.cell_y;
			prev_pixel_x_q <= item.pixel_x;
			prev_pixel_y_q <= item.pixel_y;
			if (kind == mec_pkg::EV_PRESS) begin
				press_buttons_q <= btn_sw;
				press_cell_x_q  <= item.cell_x;
				press_cell_y_q  <= item.cell_y;
				press_time_q    <= item.time_ms;
				repeat_base_q   <= item.time_ms;
				repeat_wait_q   <= rep_delay;
			end else if (kind == mec_pkg::EV_REPEAT) begin
				repeat_base_q <= item.time_ms;
				repeat_wait_q <= WAIT_W'(TICK_MS);
			end
		end
	end

endmodule

### hw/rtl/mec_checker.sv
// port-level checks of the mouse event classifier and their binding
module mec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input mec_pkg::out_item_t out_data
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// nothing carries all-zero fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == mec_pkg::EV_NONE |-> out_data == '0)
		else $error("nothing result with nonzero fields");

	// release reports no buttons and no origin
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == mec_pkg::EV_RELEASE
		|-> out_data.out_buttons == 3'd0 && out_data.from_x == 8'd0
			&& out_data.from_y == 8'd0)
		else $error("bad release result");

	// press, move and repeat always carry some button
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_kind == mec_pkg::EV_PRESS
			|| out_data.event_kind == mec_pkg::EV_MOVE
			|| out_data.event_kind == mec_pkg::EV_REPEAT)
		|-> out_data.out_buttons != 3'd0)
		else $error("button event without buttons");

	// no kind beyond auto-repeat
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_kind <= mec_pkg::EV_REPEAT)
		else $error("illegal event kind");

endmodule

bind mouse_event_classifier mec_checker u_mec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
